// ----- rtl/ipg_pkg.sv -----
`timescale 1ns / 1ps
package ipg_pkg;

    localparam int IDX_W      = 12;
    localparam int STEP_W     = 12;
    localparam int COORD_W    = 25;
    localparam int ANG_W      = 32;
    localparam int CORDIC_N   = 28;

    localparam logic [1:0] CFG_BASE    = 2'd0;
    localparam logic [1:0] CFG_OUTSIDE = 2'd1;
    localparam logic [1:0] CFG_STEPS   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RADIUS_ERR = 2'd1;
    localparam logic [1:0] ST_INDEX_ERR  = 2'd2;

    localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic [32:0] ANG_FOUR_PI        = 33'd3373259426;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
    localparam logic signed [31:0] COORD_LIMIT = 32'sd16777215;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SQUARE,
        CS_DIFF,
        CS_ROOT
    } t_cfg_state;

    typedef struct packed {
        logic [1:0] status;
        logic       last;
        logic       zero;
        logic       sat;
    } t_div_tag;

    typedef struct packed {
        logic [ANG_W-1:0] t;
        logic [1:0]       status;
        logic             last;
        logic             flip;
    } t_cord_tag;

    function automatic logic signed [31:0] atan_step(input int i);
        logic signed [31:0] v;
        case (i)
            0: v = 32'sd210828714;
            1: v = 32'sd124459457;
            2: v = 32'sd65760959;
            3: v = 32'sd33381290;
            4: v = 32'sd16755422;
            5: v = 32'sd8385879;
            6: v = 32'sd4193963;
            7: v = 32'sd2097109;
            8: v = 32'sd1048571;
            9: v = 32'sd524287;
            default: v = 32'sd1 <<< (28 - i);
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/ipg_in_if.sv -----
`timescale 1ns / 1ps
interface ipg_in_if;
    logic                      valid;
    logic                      ready;
    logic [ipg_pkg::IDX_W-1:0] point_index;

    modport source (output valid, output point_index, input ready);
    modport sink (input valid, input point_index, output ready);
endinterface

// ----- rtl/ipg_out_if.sv -----
`timescale 1ns / 1ps
interface ipg_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ipg_pkg::COORD_W-1:0] x_coord;
    logic signed [ipg_pkg::COORD_W-1:0] y_coord;
    logic [1:0]                         status;
    logic                               last_point;

    modport source (output valid, output x_coord, output y_coord, output status,
                    output last_point, input ready);
    modport sink (input valid, input x_coord, input y_coord, input status,
                  input last_point, output ready);
endinterface

// ----- rtl/ipg_cfg.sv -----
`timescale 1ns / 1ps
module ipg_cfg #(
    parameter int RADIUS_WIDTH = 24,
    parameter int MAX_STEPS    = 4095,
    parameter int DATA_W       = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [1:0]                        i_idx,
    input  logic [DATA_W-1:0]                 i_data,
    output logic [RADIUS_WIDTH-1:0]           o_base,
    output logic [RADIUS_WIDTH-1:0]           o_root,
    output logic [RADIUS_WIDTH+ipg_pkg::STEP_W-1:0] o_den,
    output logic [ipg_pkg::STEP_W-1:0]        o_steps,
    output logic                              o_rfault,
    output logic                              o_busy
);
    localparam int RW  = RADIUS_WIDTH;
    localparam int SW  = ipg_pkg::STEP_W;
    localparam int CW  = (RW > 1) ? $clog2(RW) : 1;

    logic [RW-1:0]      r_base, r_outs;
    logic [SW-1:0]      r_steps, r_steps_sat;
    logic [2*RW-1:0]    r_sq_o, r_sq_b, r_rad;
    logic [RW+SW-1:0]   r_den;
    logic               r_rfault;
    logic [RW+1:0]      r_rem;
    logic [RW-1:0]      r_root;
    logic [CW-1:0]      r_cnt;
    ipg_pkg::t_cfg_state r_state, n_state;

    logic [RW+1:0] n_shift, n_trial;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipg_pkg::CS_IDLE:   n_state = ipg_pkg::CS_IDLE;
            ipg_pkg::CS_SQUARE: n_state = ipg_pkg::CS_DIFF;
            ipg_pkg::CS_DIFF:   n_state = ipg_pkg::CS_ROOT;
            ipg_pkg::CS_ROOT:   n_state = (r_cnt == '0) ? ipg_pkg::CS_IDLE : ipg_pkg::CS_ROOT;
            default:            n_state = ipg_pkg::CS_IDLE;
        endcase
        // Any write restarts the derived-value computation.
        if (i_we) begin
            n_state = ipg_pkg::CS_SQUARE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipg_pkg::CS_SQUARE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RW'(4096);
            r_outs  <= RW'(8192);
            r_steps <= SW'(16);
        end else if (i_we) begin
            case (i_idx)
                ipg_pkg::CFG_BASE:    r_base  <= i_data[RW-1:0];
                ipg_pkg::CFG_OUTSIDE: r_outs  <= i_data[RW-1:0];
                ipg_pkg::CFG_STEPS:   r_steps <= i_data[SW-1:0];
                default: ;
            endcase
        end
    end

    assign n_shift = {r_rem[RW-1:0], r_rad[2*RW-1 -: 2]};
    assign n_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        case (r_state)
            ipg_pkg::CS_SQUARE: begin
                r_sq_o      <= r_outs * r_outs;
                r_sq_b      <= r_base * r_base;
                r_steps_sat <= (32'(r_steps) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS) : r_steps;
            end
            ipg_pkg::CS_DIFF: begin
                r_rad    <= r_sq_o - r_sq_b;
                r_den    <= r_base * r_steps_sat;
                r_rfault <= (r_outs <= r_base);
                r_rem    <= '0;
                r_root   <= '0;
                r_cnt    <= CW'(RW - 1);
            end
            ipg_pkg::CS_ROOT: begin
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt - 1'b1;
                if (n_shift >= n_trial) begin
                    r_rem  <= n_shift - n_trial;
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_base   = r_base;
    assign o_root   = r_root;
    assign o_den    = r_den;
    assign o_steps  = r_steps_sat;
    assign o_rfault = r_rfault;
    assign o_busy   = (r_state != ipg_pkg::CS_IDLE);
endmodule

// ----- rtl/ipg_div.sv -----
`timescale 1ns / 1ps
module ipg_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 36
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    input  ipg_pkg::t_div_tag            i_tag,
    output logic                         o_vld,
    output logic [ipg_pkg::ANG_W-1:0]    o_q,
    output ipg_pkg::t_div_tag            o_tag
);
    localparam int QW = ipg_pkg::ANG_W;
    localparam int FB = 28;
    localparam int WW = (NUM_W + FB > DEN_W + QW) ? NUM_W + FB : DEN_W + QW;

    logic [WW-1:0]     r_rem [0:QW];
    logic [QW-1:0]     r_q   [0:QW];
    ipg_pkg::t_div_tag r_tag [0:QW];
    logic              r_vld [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= WW'(i_num) << FB;
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [WW-1:0] n_trial;
        assign n_trial = WW'(i_den) << (QW - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j+1] <= r_tag[j];
                if (r_rem[j] >= n_trial) begin
                    r_rem[j+1] <= r_rem[j] - n_trial;
                    r_q[j+1]   <= r_q[j] | (QW'(1) << (QW - 1 - j));
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_q[j+1]   <= r_q[j];
                end
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_q   = r_q[QW];
    assign o_tag = r_tag[QW];
endmodule

// ----- rtl/ipg_cordic.sv -----
`timescale 1ns / 1ps
module ipg_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [31:0]  i_ang,
    input  ipg_pkg::t_cord_tag  i_tag,
    output logic                o_vld,
    output logic signed [31:0]  o_sin,
    output logic signed [31:0]  o_cos,
    output ipg_pkg::t_cord_tag  o_tag
);
    localparam int N = ipg_pkg::CORDIC_N;

    logic signed [31:0] r_x [0:N];
    logic signed [31:0] r_y [0:N];
    logic signed [31:0] r_z [0:N];
    ipg_pkg::t_cord_tag r_tag [0:N];
    logic               r_vld [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= ipg_pkg::CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= i_ang;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [31:0] n_dx, n_dy;
        assign n_dx = r_y[i] >>> i;
        assign n_dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[i+1] <= r_tag[i];
                if (!r_z[i][31]) begin
                    r_x[i+1] <= r_x[i] - n_dx;
                    r_y[i+1] <= r_y[i] + n_dy;
                    r_z[i+1] <= r_z[i] - ipg_pkg::atan_step(i);
                end else begin
                    r_x[i+1] <= r_x[i] + n_dx;
                    r_y[i+1] <= r_y[i] - n_dy;
                    r_z[i+1] <= r_z[i] + ipg_pkg::atan_step(i);
                end
            end
        end
    end

    assign o_vld = r_vld[N];
    assign o_sin = r_y[N];
    assign o_cos = r_x[N];
    assign o_tag = r_tag[N];
endmodule

// ----- rtl/involute_point_generator.sv -----
`timescale 1ns / 1ps
// Channel   Role    Payload
// i_pt      sink    point_index
// o_pt      source  x_coord, y_coord, status, last_point
// i_cfg_*   write   base_radius (0), outside_radius (1), step_count (2)
//
// One point enters per cycle while input ready is high; the pipeline holds
// the 32-stage angle divider and the 28-stage CORDIC. After reset and after
// every register write, input ready stays low while the square root of
// ro^2 - rb^2 and rb * steps are recomputed one root bit per cycle.
// Reset is synchronous and active low. A stall on the output freezes the
// pipeline only once the output skid register is full.
module involute_point_generator #(
    parameter int RADIUS_WIDTH = 24,
    parameter int MAX_STEPS    = 4095
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [((RADIUS_WIDTH > 12) ? RADIUS_WIDTH : 12)-1:0] i_cfg_data,
    ipg_in_if.sink            i_pt,
    ipg_out_if.source         o_pt
);
    localparam int RW    = RADIUS_WIDTH;
    localparam int SW    = ipg_pkg::STEP_W;
    localparam int IW    = ipg_pkg::IDX_W;
    localparam int DW    = (RW > 12) ? RW : 12;
    localparam int NUM_W = IW + RW;
    localparam int DEN_W = RW + SW;
    localparam int CW    = ipg_pkg::COORD_W;

    logic [RW-1:0]    w_base, w_root;
    logic [DEN_W-1:0] w_den;
    logic [SW-1:0]    w_steps;
    logic             w_rfault, w_busy;
    logic             w_en;

    ipg_cfg #(.RADIUS_WIDTH(RW), .MAX_STEPS(MAX_STEPS), .DATA_W(DW)) u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_we), .i_idx(i_cfg_idx),
        .i_data(i_cfg_data), .o_base(w_base), .o_root(w_root), .o_den(w_den),
        .o_steps(w_steps), .o_rfault(w_rfault), .o_busy(w_busy)
    );

    logic r_sk_vld;
    assign w_en       = !r_sk_vld;
    assign i_pt.ready = w_en && !w_busy;

    // Stage 0: classify the index.
    logic          r0_vld, r0_last;
    logic [IW-1:0] r0_idx;
    logic [1:0]    r0_status;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_pt.valid && !w_busy;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_idx  <= i_pt.point_index;
            r0_last <= (i_pt.point_index == w_steps);
            if (w_rfault) begin
                r0_status <= ipg_pkg::ST_RADIUS_ERR;
            end else if (i_pt.point_index > w_steps) begin
                r0_status <= ipg_pkg::ST_INDEX_ERR;
            end else begin
                r0_status <= ipg_pkg::ST_OK;
            end
        end
    end

    // Stage 1: numerator.
    logic             r1_vld, r1_last;
    logic [NUM_W-1:0] r1_num;
    logic [1:0]       r1_status;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= r0_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_num    <= r0_idx * w_root;
            r1_status <= r0_status;
            r1_last   <= r0_last;
        end
    end

    // Stage 2: zero and saturation checks ahead of the divider.
    logic              r2_vld;
    logic [NUM_W-1:0]  r2_num;
    ipg_pkg::t_div_tag r2_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_num        <= r1_num;
            r2_tag.status <= r1_status;
            r2_tag.last   <= r1_last;
            r2_tag.zero   <= (r1_num == '0) || (w_den == '0);
            r2_tag.sat    <= ((NUM_W+4)'(r1_num) >= {w_den, 4'b0000}) ? 1'b1 : 1'b0;
        end
    end

    logic                      w_dv_vld;
    logic [ipg_pkg::ANG_W-1:0] w_dv_q;
    ipg_pkg::t_div_tag         w_dv_tag;
    ipg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r2_vld),
        .i_num(r2_num), .i_den(w_den), .i_tag(r2_tag),
        .o_vld(w_dv_vld), .o_q(w_dv_q), .o_tag(w_dv_tag)
    );

    // Angle select and first reduction modulo 2*pi.
    logic [31:0] n_t;
    logic [32:0] n_a1;
    always_comb begin
        if (w_dv_tag.zero) begin
            n_t = '0;
        end else if (w_dv_tag.sat) begin
            n_t = '1;
        end else begin
            n_t = w_dv_q;
        end
        if ({1'b0, n_t} >= ipg_pkg::ANG_FOUR_PI) begin
            n_a1 = {1'b0, n_t} - ipg_pkg::ANG_FOUR_PI;
        end else if ({1'b0, n_t} >= 33'(ipg_pkg::ANG_TWO_PI)) begin
            n_a1 = {1'b0, n_t} - 33'(ipg_pkg::ANG_TWO_PI);
        end else begin
            n_a1 = {1'b0, n_t};
        end
    end

    logic               r3_vld, r4_vld, r5_vld;
    logic signed [33:0] r3_a, r4_a;
    logic signed [31:0] r5_a;
    ipg_pkg::t_cord_tag r3_tag, r4_tag, r5_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_dv_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a          <= $signed({1'b0, n_a1});
            r3_tag.t      <= n_t;
            r3_tag.status <= w_dv_tag.status;
            r3_tag.last   <= w_dv_tag.last;
            r3_tag.flip   <= 1'b0;
            r4_tag        <= r3_tag;
            r4_a          <= (r3_a > ipg_pkg::ANG_PI) ? r3_a - ipg_pkg::ANG_TWO_PI : r3_a;
            r5_tag.t      <= r4_tag.t;
            r5_tag.status <= r4_tag.status;
            r5_tag.last   <= r4_tag.last;
            // Fold into [-pi/2, pi/2]; sine and cosine change sign on a fold.
            if (r4_a > ipg_pkg::ANG_HALF_PI) begin
                r5_a        <= 32'(r4_a - ipg_pkg::ANG_PI);
                r5_tag.flip <= 1'b1;
            end else if (r4_a < -ipg_pkg::ANG_HALF_PI) begin
                r5_a        <= 32'(r4_a + ipg_pkg::ANG_PI);
                r5_tag.flip <= 1'b1;
            end else begin
                r5_a        <= 32'(r4_a);
                r5_tag.flip <= 1'b0;
            end
        end
    end

    logic               w_cd_vld;
    logic signed [31:0] w_sin, w_cos;
    ipg_pkg::t_cord_tag w_cd_tag;
    ipg_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r5_vld),
        .i_ang(r5_a), .i_tag(r5_tag), .o_vld(w_cd_vld), .o_sin(w_sin),
        .o_cos(w_cos), .o_tag(w_cd_tag)
    );

    // Sign fix, products with t, brackets, scale by rb, saturate.
    logic               r6_vld, r7_vld, r8_vld, r9_vld;
    logic signed [31:0] r6_s, r6_c, r7_s, r7_c;
    logic [31:0]        r6_t;
    logic signed [64:0] r7_ts, r7_tc;
    logic signed [25:0] r8_bx, r8_by;
    logic signed [RW+26:0] r9_px, r9_py;
    logic [1:0]         r6_st, r7_st, r8_st, r9_st;
    logic               r6_l, r7_l, r8_l, r9_l;

    logic signed [37:0] n_bx, n_by;
    assign n_bx = 38'(r7_c) + 38'(r7_ts >>> 28);
    assign n_by = 38'(r7_s) - 38'(r7_tc >>> 28);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= w_cd_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_s  <= w_cd_tag.flip ? -w_sin : w_sin;
            r6_c  <= w_cd_tag.flip ? -w_cos : w_cos;
            r6_t  <= w_cd_tag.t;
            r6_st <= w_cd_tag.status;
            r6_l  <= w_cd_tag.last;
            r7_ts <= $signed({1'b0, r6_t}) * r6_s;
            r7_tc <= $signed({1'b0, r6_t}) * r6_c;
            r7_s  <= r6_s;
            r7_c  <= r6_c;
            r7_st <= r6_st;
            r7_l  <= r6_l;
            r8_bx <= 26'(n_bx >>> 12);
            r8_by <= 26'(n_by >>> 12);
            r8_st <= r7_st;
            r8_l  <= r7_l;
            r9_px <= $signed({1'b0, w_base}) * r8_bx;
            r9_py <= $signed({1'b0, w_base}) * r8_by;
            r9_st <= r8_st;
            r9_l  <= r8_l;
        end
    end

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [RW+26:0] p,
                                                       input logic [1:0] st);
        logic signed [RW+26:0] v;
        logic signed [CW-1:0]  r;
        v = p >>> 16;
        if (v > (RW+27)'(ipg_pkg::COORD_LIMIT)) begin
            r = CW'(ipg_pkg::COORD_LIMIT);
        end else if (v < -((RW+27)'(ipg_pkg::COORD_LIMIT))) begin
            r = -(CW'(ipg_pkg::COORD_LIMIT));
        end else begin
            r = CW'(v);
        end
        if (st != ipg_pkg::ST_OK) begin
            r = '0;
        end
        return r;
    endfunction

    logic                 r_o_vld, r_o_l, r_sk_l;
    logic signed [CW-1:0] r_o_x, r_o_y, r_sk_x, r_sk_y;
    logic [1:0]           r_o_st, r_sk_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r9_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_x  <= sat_coord(r9_px, r9_st);
            r_o_y  <= sat_coord(r9_py, r9_st);
            r_o_st <= r9_st;
            r_o_l  <= r9_l;
        end
    end

    // Skid register: catches the final stage when the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (o_pt.ready) begin
                r_sk_vld <= 1'b0;
            end
        end else if (r_o_vld && !o_pt.ready) begin
            r_sk_vld <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_x  <= r_o_x;
            r_sk_y  <= r_o_y;
            r_sk_st <= r_o_st;
            r_sk_l  <= r_o_l;
        end
    end

    assign o_pt.valid      = r_sk_vld || r_o_vld;
    assign o_pt.x_coord    = r_sk_vld ? r_sk_x : r_o_x;
    assign o_pt.y_coord    = r_sk_vld ? r_sk_y : r_o_y;
    assign o_pt.status     = r_sk_vld ? r_sk_st : r_o_st;
    assign o_pt.last_point = r_sk_vld ? r_sk_l : r_o_l;
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [ipg_pkg::COORD_W-1:0] x_coord;
        logic signed [ipg_pkg::COORD_W-1:0] y_coord;
        logic [1:0]                         status;
        logic                               last_point;
    } t_point;

    class involute_scoreboard;
        logic [23:0]    base_r;
        logic [23:0]    outer_r;
        logic [11:0]    steps;
        t_point         pending_points[$];
        int             errors;
        longint         atan_tab[ipg_pkg::CORDIC_N];

        function new();
            longint fixed_part[10] = '{210828714, 124459457, 65760959, 33381290,
                16755422, 8385879, 4193963, 2097109, 1048571, 524287};
            base_r  = 24'd4096;
            outer_r = 24'd8192;
            steps   = 12'd16;
            errors  = 0;
            for (int i = 0; i < ipg_pkg::CORDIC_N; i++)
                atan_tab[i] = (i < 10) ? fixed_part[i] : (longint'(1) << (28 - i));
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                ipg_pkg::CFG_BASE:    base_r = data;
                ipg_pkg::CFG_OUTSIDE: outer_r = data;
                ipg_pkg::CFG_STEPS:   steps = data[11:0];
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint clamp_scale(longint rb, longint bracket);
            longint v;
            v = (rb * (bracket >>> 12)) >>> 16;
            if (v > 16777215)
                v = 16777215;
            if (v < -16777215)
                v = -16777215;
            return v;
        endfunction

        function t_point involute_point(logic [11:0] idx);
            t_point p;
            longint unsigned rb, ro, num, den, t, rem;
            longint ang, x, y, z, dx, dy, sn, cs, ts, tc;
            bit flip;
            rb = base_r;
            ro = outer_r;
            p.x_coord = '0;
            p.y_coord = '0;
            p.last_point = (idx == steps);
            if (ro <= rb)
                p.status = ipg_pkg::ST_RADIUS_ERR;
            else if (idx > steps)
                p.status = ipg_pkg::ST_INDEX_ERR;
            else
                p.status = ipg_pkg::ST_OK;
            if (p.status == ipg_pkg::ST_OK) begin
                num = longint'(idx) * isqrt(ro * ro - rb * rb);
                den = rb * longint'(steps);
                if (num == 0 || den == 0) begin
                    t = 0;
                end else if (num >= (den << 4)) begin
                    t = 64'hFFFFFFFF;
                end else begin
                    rem = num % den;
                    t = num / den;
                    for (int i = 0; i < 28; i++) begin
                        rem <<= 1;
                        t <<= 1;
                        if (rem >= den) begin
                            rem -= den;
                            t |= 1;
                        end
                    end
                end
                // Fold the angle into [-pi/2, pi/2] before the rotation.
                ang = t;
                flip = 0;
                while (ang >= 1686629713)
                    ang -= 1686629713;
                if (ang > 843314857)
                    ang -= 1686629713;
                if (ang > 421657428) begin
                    ang -= 843314857;
                    flip = 1;
                end else if (ang < -421657428) begin
                    ang += 843314857;
                    flip = 1;
                end
                x = 163008219;
                y = 0;
                z = ang;
                for (int i = 0; i < ipg_pkg::CORDIC_N; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx;
                        y += dy;
                        z -= atan_tab[i];
                    end else begin
                        x += dx;
                        y -= dy;
                        z += atan_tab[i];
                    end
                end
                sn = flip ? -y : y;
                cs = flip ? -x : x;
                ts = (longint'(t) * sn) >>> 28;
                tc = (longint'(t) * cs) >>> 28;
                p.x_coord = ipg_pkg::COORD_W'(clamp_scale(rb, cs + ts));
                p.y_coord = ipg_pkg::COORD_W'(clamp_scale(rb, sn - tc));
            end
            return p;
        endfunction

        function void note_index(logic [11:0] idx);
            pending_points.push_back(involute_point(idx));
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (pending_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d", got.x_coord, got.y_coord);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            if (got.x_coord !== want.x_coord) begin
                $error("x_coord expected %0d got %0d", want.x_coord, got.x_coord);
                errors++;
            end
            if (got.y_coord !== want.y_coord) begin
                $error("y_coord expected %0d got %0d", want.y_coord, got.y_coord);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.last_point !== want.last_point) begin
                $error("last_point expected %0d got %0d", want.last_point, got.last_point);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    ipg_in_if  pt_in ();
    ipg_out_if pt_out ();

    involute_point_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_in.sink),
        .o_pt       (pt_out.source)
    );

    involute_scoreboard points = new();
    bit  idle_enabled = 1;
    bit  hold_request = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #20ms;
        $display("FAIL involute_point_generator");
        $finish;
    end

    // The receiver either waits a random gap per transaction while gaps are
    // enabled, or holds off for one long stretch when asked to.
    initial begin
        int gap;
        pt_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                pt_out.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                gap = idle_enabled ? $urandom_range(0, 6) : 0;
                if (gap > 0) begin
                    pt_out.ready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            pt_out.ready = 1'b1;
            do @(posedge i_clk); while (!pt_out.valid);
        end
    end

    always @(posedge i_clk) begin
        t_point got;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            got.x_coord = pt_out.x_coord;
            got.y_coord = pt_out.y_coord;
            got.status = pt_out.status;
            got.last_point = pt_out.last_point;
            points.check_point(got);
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_point(input logic [11:0] idx);
        int gap;
        pt_in.valid = 1'b1;
        pt_in.point_index = idx;
        do @(posedge i_clk); while (!pt_in.ready);
        points.note_index(idx);
        @(negedge i_clk);
        gap = idle_enabled ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            pt_in.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        points.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        pt_in.valid = 1'b0;
        while (points.pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [23:0] rb, input logic [23:0] ro,
                             input logic [23:0] st);
        drain();
        write_reg(ipg_pkg::CFG_BASE, rb);
        write_reg(ipg_pkg::CFG_OUTSIDE, ro);
        write_reg(ipg_pkg::CFG_STEPS, st);
    endtask

    task automatic random_points(input int count);
        logic [11:0] idx;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                idle_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
                idx = 12'($urandom_range(0, points.steps));
            else
                idx = 12'($urandom_range(0, 4095));
            send_point(idx);
        end
    endtask

    initial begin
        logic [23:0] rb;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ipg_pkg::CFG_BASE;
        i_cfg_data = '0;
        pt_in.valid = 1'b0;
        pt_in.point_index = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed points on the reset setting: both ends, inner points, beyond
        // the end, the largest index.
        send_point(12'd0);
        send_point(12'd1);
        send_point(12'd8);
        send_point(12'd16);
        send_point(12'd17);
        send_point(12'd4095);
        send_point(12'd2730);

        // Outside radius equal to and below the base radius.
        configure(24'd8192, 24'd8192, 24'd16);
        send_point(12'd5);
        send_point(12'd16);
        send_point(12'd40);
        drain();
        write_reg(ipg_pkg::CFG_OUTSIDE, 24'd100);
        send_point(12'd3);

        // Zero base radius, zero step count, a write to an unused index.
        configure(24'd0, 24'd4096, 24'd0);
        send_point(12'd0);
        send_point(12'd1);
        drain();
        write_reg(ipg_pkg::CFG_BASE, 24'd4096);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_point(12'd0);
        send_point(12'd4095);

        // Extreme radii and step count; the angle saturates past index 0.
        configure(24'd1, 24'hFFFFFF, 24'hFFFFFF);
        send_point(12'd4095);
        send_point(12'd1);
        send_point(12'd2048);
        configure(24'hFFFFFE, 24'hFFFFFF, 24'h000001);
        send_point(12'd0);
        send_point(12'd1);
        send_point(12'd2);

        // Make the output stall long enough to back up the input.
        drain();
        idle_enabled = 0;
        hold_request = 1;
        random_points(120);

        configure(24'd4096, 24'd8192, 24'd16);
        random_points(90);
        configure(24'd2048, 24'd40960, 24'd4095);
        random_points(120);
        configure(24'd1, 24'hFFFFFF, 24'd4095);
        random_points(80);
        for (int p = 0; p < 5; p++) begin
            rb = 24'($urandom_range(1, 24'h3FFFFF));
            configure(rb, 24'(rb + $urandom_range(1, 24'h3FFFFF)),
                      24'($urandom_range(1, 4095)));
            random_points(50);
        end
        configure(24'($urandom & 24'hFFFFFF), 24'($urandom & 24'hFFFFFF),
                  24'($urandom & 24'hFFFFFF));
        random_points(60);

        drain();
        if (points.errors == 0)
            $display("PASS involute_point_generator");
        else
            $display("FAIL involute_point_generator");
        $finish;
    end
endmodule
